// ===== rtl/tpsd_pkg.sv =====
package tpsd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_STEP_COUNT   = 3'd0,
    CFG_STEP_POSES   = 3'd1,
    CFG_STEP_HOLDS   = 3'd2,
    CFG_DURATIONS_LO = 3'd3,
    CFG_DURATIONS_HI = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] pose_match_mask;
  } in_t;

  typedef struct packed {
    status_e    seq_status;
    logic [3:0] step_position;
  } out_t;

  typedef struct packed {
    logic [3:0]  step_count;
    logic [31:0] step_pose_ids;
    logic [7:0]  step_hold_flags;
    logic [63:0] durations_low;
    logic [63:0] durations_high;
  } cfg_t;

endpackage

// ===== rtl/timed_pose_sequence_detector_core.sv =====
// Tracks progress through a configured sequence of timed poses and returns one result beat,
// status and awaited step, for every input beat, in order. A beat is captured in the input
// register, evaluated against the sequence state once the result register can take it, and
// written to the result register together with the updated state. One beat is taken every
// cycle while the result is not stalled; the state is updated once per beat, which sets
// that rate. The input side stalls only while both registers are full and the result is
// stalled. Configuration writes must only happen while no beat is in flight.
module timed_pose_sequence_detector_core #(
  parameter int unsigned MAX_STEPS = 8,
  parameter int unsigned NUM_POSES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpsd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tpsd_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tpsd_pkg::out_t                out_data_o
);
  import tpsd_pkg::*;

  cfg_t cfg;
  in_t  in_d, in_q;
  logic in_vld_d, in_vld_q;
  out_t out_d, out_q;
  logic out_vld_d, out_vld_q;
  out_t res;
  logic out_free;
  logic fire;

  tpsd_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  tpsd_eval #(
    .MAX_STEPS (MAX_STEPS),
    .NUM_POSES (NUM_POSES)
  ) u_eval (
    .clk_i,
    .rst_ni,
    .upd_i (fire),
    .in_i  (in_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !fire;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_d      = in_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
      if (in_valid_i) begin
        in_d = in_data_i;
      end
    end
    if (out_free) begin
      out_vld_d = fire;
      if (fire) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/tpsd_cfg.sv =====
module tpsd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpsd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output tpsd_pkg::cfg_t                cfg_o
);
  import tpsd_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_COUNT:   cfg_d.step_count      = cfg_wdata_i[3:0];
        CFG_STEP_POSES:   cfg_d.step_pose_ids   = cfg_wdata_i[31:0];
        CFG_STEP_HOLDS:   cfg_d.step_hold_flags = cfg_wdata_i[7:0];
        CFG_DURATIONS_LO: cfg_d.durations_low   = cfg_wdata_i;
        CFG_DURATIONS_HI: cfg_d.durations_high  = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count      <= 4'd1;
      cfg_q.step_pose_ids   <= '0;
      cfg_q.step_hold_flags <= '0;
      cfg_q.durations_low   <= '0;
      cfg_q.durations_high  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tpsd_eval.sv =====
module tpsd_eval #(
  parameter int unsigned MAX_STEPS = 8,
  parameter int unsigned NUM_POSES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  tpsd_pkg::in_t  in_i,
  input  tpsd_pkg::cfg_t cfg_i,
  output tpsd_pkg::out_t res_o
);
  import tpsd_pkg::*;

  localparam logic [3:0] MaxCount = 4'(MAX_STEPS);
  localparam logic [4:0] PoseLim  = 5'(NUM_POSES);

  logic [3:0]  step_idx_d, step_idx_q;
  logic [31:0] timer_d, timer_q;
  logic [2:0]  last_step_d, last_step_q;
  logic        last_vld_d, last_vld_q;
  logic        hold_d, hold_q;
  status_e     status_d, status_q;

  logic [3:0]   count;
  logic         restart;
  logic [3:0]   r_idx;
  logic [31:0]  r_timer;
  logic         r_lvld;
  logic         r_hold;
  status_e      r_status;
  logic [2:0]   s;
  logic [3:0]   pose;
  logic         matched;
  logic         is_hold;
  logic [127:0] durs;
  logic [15:0]  dur;
  logic [31:0]  elapsed;
  logic         expired;

  always_comb begin
    if (cfg_i.step_count == 4'd0) begin
      count = 4'd1;
    end else if (cfg_i.step_count > MaxCount) begin
      count = MaxCount;
    end else begin
      count = cfg_i.step_count;
    end
  end

  assign restart = (step_idx_q >= count) || (status_q == ST_FAIL) || (status_q == ST_DONE);
  assign r_idx    = restart ? 4'd0 : step_idx_q;
  assign r_timer  = restart ? in_i.now_ms : timer_q;
  assign r_lvld   = restart ? 1'b0 : last_vld_q;
  assign r_hold   = restart ? 1'b0 : hold_q;
  assign r_status = restart ? ST_IDLE : status_q;

  assign s       = r_idx[2:0];
  assign pose    = cfg_i.step_pose_ids[{s, 2'b00} +: 4];
  assign matched = ({1'b0, pose} < PoseLim) && in_i.pose_match_mask[pose];
  assign is_hold = cfg_i.step_hold_flags[s];
  assign durs    = {cfg_i.durations_high, cfg_i.durations_low};
  assign dur     = durs[{s, 4'b0000} +: 16];
  assign elapsed = in_i.now_ms - r_timer;
  assign expired = elapsed >= {16'd0, dur};

  always_comb begin
    step_idx_d  = r_idx;
    timer_d     = r_timer;
    last_step_d = restart ? 3'd0 : last_step_q;
    last_vld_d  = r_lvld;
    hold_d      = r_hold;
    status_d    = r_status;
    if (matched) begin
      last_step_d = s;
      last_vld_d  = 1'b1;
      if (is_hold) begin
        if (r_lvld && (last_step_q == s) && !restart) begin
          if (expired) begin
            step_idx_d = {1'b0, s} + 4'd1;
          end
          hold_d = 1'b1;
        end else begin
          timer_d = in_i.now_ms;
        end
      end else begin
        step_idx_d = {1'b0, s} + 4'd1;
        timer_d    = in_i.now_ms;
      end
      status_d = (step_idx_d == count) ? ST_DONE : ST_RUN;
    end else if (r_hold) begin
      hold_d   = 1'b0;
      status_d = ST_FAIL;
    end else if (r_idx != 4'd0) begin
      status_d = expired ? ST_FAIL : ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_idx_q  <= 4'd0;
      timer_q     <= '0;
      last_step_q <= 3'd0;
      last_vld_q  <= 1'b0;
      hold_q      <= 1'b0;
      status_q    <= ST_IDLE;
    end else if (upd_i) begin
      step_idx_q  <= step_idx_d;
      timer_q     <= timer_d;
      last_step_q <= last_step_d;
      last_vld_q  <= last_vld_d;
      hold_q      <= hold_d;
      status_q    <= status_d;
    end
  end

  assign res_o.seq_status    = status_d;
  assign res_o.step_position = step_idx_d;

endmodule

// ===== rtl/tpsd_checker.sv =====
module tpsd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tpsd_pkg::out_t out_data_o
);
  import tpsd_pkg::*;

  logic [1:0] cnt_d, cnt_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !out_valid_o)
    else $error("result beat without a pending input beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cnt_q == 2'd0) |-> ##2 out_valid_o)
    else $error("result beat not produced two cycles after input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (cnt_q == 2'd2) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.seq_status == ST_IDLE) |-> (out_data_o.step_position == 4'd0))
    else $error("sequence not started but step position is nonzero");

endmodule

bind timed_pose_sequence_detector_core tpsd_checker u_checker (.*);
